// ===== hw/rtl/ppt_pkg.sv =====
`default_nettype none

package ppt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int FUNC_W = 2;
    localparam int ADDR_W = 32;
    localparam int PLEN_W = 6;
    localparam int PORT_W = 16;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    // request held for the whole operation, broadcast to every cell
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
        logic              pol;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
        logic              pol;
    } t_ent;

    typedef struct packed {
        logic adv;     // token moves one cell right
        logic clr;     // drop all tokens
        logic shift;   // token cell copies its right neighbor
        logic setpol;  // token cell takes the request policy
        logic load;    // this cell takes the request as a new entry
    } t_cell_ctl;

    typedef struct packed {
        logic hit_lk;
        logic hit_ap;
        logic hit_rm;
        logic pol;
    } t_cell_sts;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        m = '0;
        if (len == '0) begin
            m = '0;
        end else if (len >= PLEN_W'(ADDR_W)) begin
            m = '1;
        end else begin
            m = ~('1 >> len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prefix_port_policy_table.sv =====
`default_nettype none

// First-match IPv4 prefix / port policy table.
// Input channel (i_valid/o_ready) carries one request beat: i_func selects
// lookup, append or remove; i_address, i_prefix_len, i_port_number and
// i_policy_bit are its operands. Output channel (o_valid/i_ready) returns one
// beat per request: o_apply (lookup verdict) and o_status.
// Entries live in a row of cells in insertion order. A token walks the row
// one cell per cycle, the token cell compares against the request, and the
// walk stops at the first hit or at the last valid entry. A remove keeps
// walking past the hit, each cell copying its right neighbor to close the gap.
// One request is worked at a time. The token visits from one cell up to the
// entry count, but at least one; a remove always walks to the last entry, and
// so does an append that adds an entry. The next request is taken in the cycle
// after the result is loaded. An unused function code skips the walk.
// Reset empties the table; no clearing pass is needed. A finished result sits
// in the output register while a new request may already be accepted; if the
// receiver stalls, the next result waits until the register is taken.

module prefix_port_policy_table (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [ppt_pkg::FUNC_W-1:0]    i_func,
    input  wire  [ppt_pkg::ADDR_W-1:0]    i_address,
    input  wire  [ppt_pkg::PLEN_W-1:0]    i_prefix_len,
    input  wire  [ppt_pkg::PORT_W-1:0]    i_port_number,
    input  wire                           i_policy_bit,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_apply,
    output logic [ppt_pkg::STAT_W-1:0]    o_status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    ppt_pkg::t_req r_req, n_req;
    logic [ppt_pkg::CNT_W-1:0]  r_count, n_count;
    logic [ppt_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_res_apply, n_res_apply;
    logic [ppt_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_apply, n_out_apply;
    logic [ppt_pkg::STAT_W-1:0] r_out_status, n_out_status;

    ppt_pkg::t_cell_ctl w_ctl;
    ppt_pkg::t_cell_ctl w_cell_ctl [ppt_pkg::TABLE_DEPTH];
    ppt_pkg::t_cell_sts w_sts      [ppt_pkg::TABLE_DEPTH];
    ppt_pkg::t_ent      w_ent      [ppt_pkg::TABLE_DEPTH];
    logic               w_tok      [ppt_pkg::TABLE_DEPTH];
    logic               w_start;

    logic w_any_lk, w_any_ap, w_any_rm, w_any_pol;
    logic w_valid_idx, w_last, w_full;
    logic [ppt_pkg::CNT_W-1:0] w_idx_ext;

    // hits are gated by the token, so a plain OR picks the token cell
    always_comb begin
        w_any_lk  = 1'b0;
        w_any_ap  = 1'b0;
        w_any_rm  = 1'b0;
        w_any_pol = 1'b0;
        for (int k = 0; k < ppt_pkg::TABLE_DEPTH; k++) begin
            w_any_lk  = w_any_lk  | w_sts[k].hit_lk;
            w_any_ap  = w_any_ap  | w_sts[k].hit_ap;
            w_any_rm  = w_any_rm  | w_sts[k].hit_rm;
            w_any_pol = w_any_pol | w_sts[k].pol;
        end
    end

    always_comb begin
        w_idx_ext   = ppt_pkg::CNT_W'(r_idx);
        w_valid_idx = w_idx_ext < r_count;
        w_last      = (w_idx_ext + ppt_pkg::CNT_W'(1)) >= r_count;
        w_full      = r_count == ppt_pkg::CNT_W'(ppt_pkg::TABLE_DEPTH);
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_apply  = r_res_apply;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_apply  = r_out_apply;
        n_out_status = r_out_status;
        w_ctl        = '0;
        w_start      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req.func   = i_func;
                    n_req.addr   = i_address;
                    n_req.plen   = i_prefix_len;
                    n_req.port   = i_port_number;
                    n_req.pol    = i_policy_bit;
                    n_res_apply  = 1'b0;
                    n_res_status = ppt_pkg::ST_OK;
                    if (i_func == ppt_pkg::FN_LOOKUP || i_func == ppt_pkg::FN_APPEND ||
                        i_func == ppt_pkg::FN_REMOVE) begin
                        w_ctl.adv = 1'b1;
                        w_start   = 1'b1;
                        n_idx     = '0;
                        n_state   = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                case (r_req.func)
                    ppt_pkg::FN_LOOKUP: begin
                        if (w_valid_idx && w_any_lk) begin
                            n_res_apply = w_any_pol;
                            n_state     = S_DONE;
                        end else if (w_last) begin
                            n_state = S_DONE;
                        end else begin
                            w_ctl.adv = 1'b1;
                            n_idx     = r_idx + 1'b1;
                        end
                    end
                    ppt_pkg::FN_APPEND: begin
                        if (w_valid_idx && w_any_ap) begin
                            w_ctl.setpol = 1'b1;
                            n_res_status = (w_any_pol == r_req.pol) ? ppt_pkg::ST_EXISTS
                                                                    : ppt_pkg::ST_UPDATED;
                            n_state      = S_DONE;
                        end else if (w_last) begin
                            if (w_full) begin
                                n_res_status = ppt_pkg::ST_FULL;
                            end else begin
                                w_ctl.load = 1'b1;
                                n_count    = r_count + 1'b1;
                            end
                            n_state = S_DONE;
                        end else begin
                            w_ctl.adv = 1'b1;
                            n_idx     = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        if (w_valid_idx && w_any_rm) begin
                            if (w_last) begin
                                n_count = r_count - 1'b1;
                                n_state = S_DONE;
                            end else begin
                                w_ctl.shift = 1'b1;
                                w_ctl.adv   = 1'b1;
                                n_idx       = r_idx + 1'b1;
                                n_state     = S_SHIFT;
                            end
                        end else if (w_last) begin
                            n_res_status = ppt_pkg::ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end else begin
                            w_ctl.adv = 1'b1;
                            n_idx     = r_idx + 1'b1;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                // close the gap: token cell pulls the entry on its right
                if (w_last) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_ctl.shift = 1'b1;
                    w_ctl.adv   = 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_ctl.clr    = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_apply  = r_res_apply;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_res_apply  <= n_res_apply;
        r_res_status <= n_res_status;
        r_out_apply  <= n_out_apply;
        r_out_status <= n_out_status;
    end

    genvar g;
    generate
        for (g = 0; g < ppt_pkg::TABLE_DEPTH; g++) begin : g_cell
            logic          w_left;
            ppt_pkg::t_ent w_right;

            always_comb begin
                w_cell_ctl[g]      = w_ctl;
                w_cell_ctl[g].load = w_ctl.load && (r_count == ppt_pkg::CNT_W'(g));
            end

            if (g == 0) begin : g_head
                assign w_left = w_start;
            end else begin : g_body
                assign w_left = w_tok[g-1];
            end

            if (g == ppt_pkg::TABLE_DEPTH - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_ent[g+1];
            end

            ppt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_req),
                .i_ctl   (w_cell_ctl[g]),
                .i_tok   (w_left),
                .o_tok   (w_tok[g]),
                .i_nxt   (w_right),
                .o_ent   (w_ent[g]),
                .o_sts   (w_sts[g])
            );
        end
    endgenerate

    assign o_ready  = r_state == S_IDLE;
    assign o_valid  = r_out_valid;
    assign o_apply  = r_out_apply;
    assign o_status = r_out_status;

endmodule

`default_nettype wire

// ===== hw/rtl/ppt_cell.sv =====
`default_nettype none

module ppt_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ppt_pkg::t_req       i_req,
    input  ppt_pkg::t_cell_ctl  i_ctl,
    input  wire                 i_tok,
    output logic                o_tok,
    input  ppt_pkg::t_ent       i_nxt,
    output ppt_pkg::t_ent       o_ent,
    output ppt_pkg::t_cell_sts  o_sts
);

    logic          r_tok;
    ppt_pkg::t_ent r_ent;

    logic [ppt_pkg::ADDR_W-1:0] w_mask;
    logic                       w_port_ok;
    logic                       w_base_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.clr) begin
            r_tok <= 1'b0;
        end else if (i_ctl.adv) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ent.addr <= i_req.addr;
            r_ent.plen <= i_req.plen;
            r_ent.port <= i_req.port;
            r_ent.pol  <= i_req.pol;
        end else if (i_ctl.shift && r_tok) begin
            r_ent <= i_nxt;
        end else if (i_ctl.setpol && r_tok) begin
            r_ent.pol <= i_req.pol;
        end
    end

    always_comb begin
        w_mask    = ppt_pkg::prefix_mask(r_ent.plen);
        w_port_ok = (r_ent.port == '0) || (r_ent.port == i_req.port);
        w_base_eq = (r_ent.addr == i_req.addr) && (r_ent.plen == i_req.plen);

        o_sts.hit_lk = r_tok && (((i_req.addr ^ r_ent.addr) & w_mask) == '0) && w_port_ok;
        o_sts.hit_ap = r_tok && w_base_eq && w_port_ok;
        o_sts.hit_rm = r_tok && w_base_eq && (r_ent.port == i_req.port);
        o_sts.pol    = r_tok && r_ent.pol;
    end

    assign o_tok = r_tok;
    assign o_ent = r_ent;

endmodule

`default_nettype wire

// ===== hw/rtl/ppt_checker.sv =====
`default_nettype none

module ppt_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_valid,
    input wire                        o_ready,
    input wire                        o_valid,
    input wire                        i_ready,
    input wire                        o_apply,
    input wire [ppt_pkg::STAT_W-1:0]  o_status
);

    // a held result beat must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_apply) && $stable(o_status))
        else $error("result beat changed while stalled");

    // only a lookup can report apply, and a lookup always reports ok
    a_apply_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_apply |-> o_status == ppt_pkg::ST_OK)
        else $error("apply set with non-ok status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ppt_pkg::ST_OK || o_status == ppt_pkg::ST_EXISTS ||
                     o_status == ppt_pkg::ST_UPDATED || o_status == ppt_pkg::ST_FULL ||
                     o_status == ppt_pkg::ST_NOT_FOUND))
        else $error("status code out of range");

    // one request in flight: no second accept right after the first
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

endmodule

bind prefix_port_policy_table ppt_checker u_ppt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_apply  (o_apply),
    .o_status (o_status)
);

`default_nettype wire

// ===== sim/prefix_port_policy_table_test.sv =====
`default_nettype none

module prefix_port_policy_table_test;

    import ppt_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int POOL_N = 96;
    localparam int MODE_SPAN = 96;    // beats sent per idling mode
    localparam int SEG_LEN = 100;
    localparam int RANDOM_ITEMS = 1080;
    localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3) + 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic              apply;
        logic [STAT_W-1:0] status;
        t_req              req;
    } t_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic [PLEN_W-1:0]    i_prefix_len = '0;
    logic [PORT_W-1:0]    i_port_number = '0;
    logic                 i_policy_bit = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_apply;
    logic [STAT_W-1:0]    o_status;

    prefix_port_policy_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_address     (i_address),
        .i_prefix_len  (i_prefix_len),
        .i_port_number (i_port_number),
        .i_policy_bit  (i_policy_bit),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_apply       (o_apply),
        .o_status      (o_status)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the rule table
    logic [ADDR_W-1:0] rule_addr [TABLE_DEPTH];
    logic [PLEN_W-1:0] rule_plen [TABLE_DEPTH];
    logic [PORT_W-1:0] rule_port [TABLE_DEPTH];
    logic              rule_pol  [TABLE_DEPTH];
    int                rule_cnt = 0;

    // prefixes that random traffic keeps coming back to
    logic [ADDR_W-1:0] pool_addr [POOL_N];
    logic [PLEN_W-1:0] pool_plen [POOL_N];
    logic [PORT_W-1:0] pool_port [POOL_N];

    t_req     pending_req_q [$];
    t_verdict expected_verdict_q [$];

    logic req_taken = 1'b0;
    int   sent_cnt = 0;
    int   mismatch_cnt = 0;

    task automatic classify_request(input t_req rq, output t_verdict v);
        logic [ADDR_W-1:0] mask;
        int i;
        int j;
        int plen_c;
        bit found;
        v.apply = 1'b0;
        v.status = ST_OK;
        v.req = rq;
        found = 1'b0;
        case (rq.func)
            FN_LOOKUP: begin
                for (i = 0; i < rule_cnt; i++) begin
                    plen_c = (rule_plen[i] > ADDR_W) ? ADDR_W : int'(rule_plen[i]);
                    mask = (plen_c == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen_c));
                    if ((((rq.addr ^ rule_addr[i]) & mask) == '0) &&
                        (rule_port[i] == '0 || rule_port[i] == rq.port)) begin
                        v.apply = rule_pol[i];
                        break;
                    end
                end
            end
            FN_APPEND: begin
                for (i = 0; i < rule_cnt; i++) begin
                    if (rule_addr[i] == rq.addr && rule_plen[i] == rq.plen &&
                        (rule_port[i] == '0 || rule_port[i] == rq.port)) begin
                        if (rule_pol[i] == rq.pol) begin
                            v.status = ST_EXISTS;
                        end else begin
                            rule_pol[i] = rq.pol;
                            v.status = ST_UPDATED;
                        end
                        found = 1'b1;
                        break;
                    end
                end
                if (!found) begin
                    if (rule_cnt >= TABLE_DEPTH) begin
                        v.status = ST_FULL;
                    end else begin
                        rule_addr[rule_cnt] = rq.addr;
                        rule_plen[rule_cnt] = rq.plen;
                        rule_port[rule_cnt] = rq.port;
                        rule_pol[rule_cnt] = rq.pol;
                        rule_cnt++;
                    end
                end
            end
            FN_REMOVE: begin
                v.status = ST_NOT_FOUND;
                for (i = 0; i < rule_cnt; i++) begin
                    if (rule_addr[i] == rq.addr && rule_plen[i] == rq.plen &&
                        rule_port[i] == rq.port) begin
                        for (j = i; j + 1 < rule_cnt; j++) begin
                            rule_addr[j] = rule_addr[j + 1];
                            rule_plen[j] = rule_plen[j + 1];
                            rule_port[j] = rule_port[j + 1];
                            rule_pol[j] = rule_pol[j + 1];
                        end
                        rule_cnt--;
                        v.status = ST_OK;
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_req mk_req(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                    logic [PLEN_W-1:0] l, logic [PORT_W-1:0] p,
                                    logic pol);
        t_req r;
        r.func = f;
        r.addr = a;
        r.plen = l;
        r.port = p;
        r.pol = pol;
        return r;
    endfunction

    function automatic logic [PORT_W-1:0] common_port();
        case ($urandom_range(0, 3))
            0: return 16'hFFFF;
            1: return 16'h0001;
            2: return 16'd80;
            default: return 16'd443;
        endcase
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_idle_mode cur_mode();
        return t_idle_mode'((sent_cnt / MODE_SPAN) % 4);
    endfunction

    // driver: new beat only once the previous one was taken
    always @(negedge i_clk) begin : drv
        t_req nxt;
        t_idle_mode m;
        m = cur_mode();
        if (i_rst_n) begin
            if (!i_valid || req_taken) begin
                if (pending_req_q.size() != 0 &&
                    !((m == IDLE_SENDER && roll(67)) || (m == IDLE_BOTH && roll(7)))) begin
                    nxt = pending_req_q.pop_front();
                    i_func <= nxt.func;
                    i_address <= nxt.addr;
                    i_prefix_len <= nxt.plen;
                    i_port_number <= nxt.port;
                    i_policy_bit <= nxt.pol;
                    i_valid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !((m == IDLE_RECEIVER && roll(67)) || (m == IDLE_BOTH && roll(7)));
        end
    end

    // monitor: predict on accepted request beats, check result beats
    always @(posedge i_clk) begin : mon
        t_req rq;
        t_verdict v;
        t_verdict e;
        req_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rq = mk_req(i_func, i_address, i_prefix_len, i_port_number, i_policy_bit);
                classify_request(rq, v);
                expected_verdict_q.push_back(v);
            end
            if (o_valid && i_ready) begin
                if (expected_verdict_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: apply=%0d status=%0d",
                                 o_apply, o_status);
                end else begin
                    e = expected_verdict_q.pop_front();
                    if (o_apply !== e.apply || o_status !== e.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("mismatch func=%0d addr=%h plen=%0d port=%0d pol=%0d:",
                                   e.req.func, e.req.addr, e.req.plen, e.req.port,
                                   e.req.pol);
                            $display(" expected apply=%0d status=%0d, got apply=%0d status=%0d",
                                     e.apply, e.status, o_apply, o_status);
                        end
                    end
                end
            end
        end
    end

    initial begin : stim
        int n;
        int p;
        int r;
        int kind;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] a;
        logic [PLEN_W-1:0] l;
        logic [PORT_W-1:0] pt;
        int plen_c;

        for (p = 0; p < POOL_N; p++) begin
            pool_addr[p] = $urandom;
            r = $urandom_range(0, 15);
            if (r == 0)
                pool_plen[p] = 6'd0;
            else if (r == 1)
                pool_plen[p] = PLEN_W'($urandom_range(33, 63));
            else
                pool_plen[p] = PLEN_W'($urandom_range(1, 32));
            r = $urandom_range(0, 2);
            pool_port[p] = (r == 0) ? 16'd0 : (r == 1) ? common_port() : PORT_W'($urandom);
        end

        // directed: empty table, unused code, wildcard port, /0 and over-long prefixes
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'h0, 6'd0, 16'd0, 1'b0));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1));
        pending_req_q.push_back(mk_req(FN_REMOVE, 32'h0A00_0000, 6'd8, 16'd80, 1'b0));
        pending_req_q.push_back(mk_req(FN_UNUSED, 32'h0A00_0000, 6'd8, 16'd80, 1'b1));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'h0A00_0000, 6'd8, 16'd80, 1'b1));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'h0A12_3456, 6'd0, 16'd80, 1'b0));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'h0A12_3456, 6'd0, 16'd81, 1'b0));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'h0A00_0000, 6'd8, 16'd80, 1'b1));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'h0A00_0000, 6'd8, 16'd80, 1'b0));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'h0AFF_FFFF, 6'd0, 16'd80, 1'b0));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'hFFFF_FFFF, 6'd32, 16'd0, 1'b1));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'd12345, 1'b0));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'hC0A8_0001, 6'd40, 16'hFFFF, 1'b1));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'hC0A8_0001, 6'd0, 16'hFFFF, 1'b0));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'hC0A8_0000, 6'd0, 16'hFFFF, 1'b0));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'h1234_5678, 6'd0, 16'd0, 1'b1));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'h0, 6'd0, 16'd0, 1'b0));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'hFFFF_FFFF, 6'd32, 16'd7, 1'b0));
        pending_req_q.push_back(mk_req(FN_REMOVE, 32'hFFFF_FFFF, 6'd32, 16'd7, 1'b0));
        pending_req_q.push_back(mk_req(FN_REMOVE, 32'hFFFF_FFFF, 6'd32, 16'd0, 1'b0));
        pending_req_q.push_back(mk_req(FN_REMOVE, 32'h0A00_0000, 6'd8, 16'd80, 1'b0));
        pending_req_q.push_back(mk_req(FN_LOOKUP, 32'hC0A8_0001, 6'd0, 16'hFFFF, 1'b0));
        pending_req_q.push_back(mk_req(FN_APPEND, 32'hC0A8_0001, 6'd63, 16'd0, 1'b0));
        pending_req_q.push_back(mk_req(FN_UNUSED, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1));

        // random: segments that grow the table to full, churn it, and drain it
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            kind = (n / SEG_LEN) % 4;
            r = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_N - 1);
            if (kind <= 1)
                r = (r < 55) ? 0 : (r < 65) ? 1 : (r < 97) ? 2 : 3;
            else if (kind == 2)
                r = (r < 30) ? 0 : (r < 55) ? 1 : (r < 97) ? 2 : 3;
            else
                r = (r < 15) ? 0 : (r < 65) ? 1 : (r < 97) ? 2 : 3;
            case (r)
                0: begin
                    if (roll(10)) begin
                        a = $urandom;
                        l = PLEN_W'($urandom_range(0, 63));
                        pt = PORT_W'($urandom);
                    end else begin
                        a = pool_addr[p];
                        l = pool_plen[p];
                        pt = roll(80) ? pool_port[p] : roll(50) ? common_port() :
                             PORT_W'($urandom);
                    end
                    pending_req_q.push_back(mk_req(FN_APPEND, a, l, pt, 1'($urandom)));
                end
                1: begin
                    a = pool_addr[p];
                    l = pool_plen[p];
                    pt = pool_port[p];
                    if (roll(25)) begin
                        case ($urandom_range(0, 2))
                            0: pt = pt ^ PORT_W'($urandom_range(1, 65535));
                            1: l = l ^ PLEN_W'($urandom_range(1, 63));
                            default: a = a ^ (32'h1 << $urandom_range(0, 31));
                        endcase
                    end
                    pending_req_q.push_back(mk_req(FN_REMOVE, a, l, pt, 1'($urandom)));
                end
                2: begin
                    plen_c = (pool_plen[p] > ADDR_W) ? ADDR_W : int'(pool_plen[p]);
                    mask = (plen_c == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen_c));
                    a = roll(70) ? ((pool_addr[p] & mask) | ($urandom & ~mask)) : $urandom;
                    pt = (pool_port[p] != '0 && roll(70)) ? pool_port[p] :
                         roll(50) ? common_port() : PORT_W'($urandom);
                    pending_req_q.push_back(mk_req(FN_LOOKUP, a, PLEN_W'($urandom), pt,
                                                   1'($urandom)));
                end
                default: begin
                    pending_req_q.push_back(mk_req(roll(50) ? FN_UNUSED :
                                                   FUNC_W'($urandom_range(0, 2)),
                                                   $urandom, PLEN_W'($urandom),
                                                   PORT_W'($urandom), 1'($urandom)));
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_req_q.size() != 0 || i_valid || expected_verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_verdict_q.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("PASS prefix_port_policy_table");
        end else begin
            $display("FAIL prefix_port_policy_table");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL prefix_port_policy_table");
        $finish;
    end

endmodule

`default_nettype wire
